// ===== rtl/kmer_d2s_distance_accumulator_unit_defines.svh =====
// Assertion macros used by the rtl checker module.
`ifndef KMER_D2S_DISTANCE_ACCUMULATOR_UNIT_DEFINES_SVH
`define KMER_D2S_DISTANCE_ACCUMULATOR_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define KDDA_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("kdda check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define KDDA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("kdda check failed");

`endif

// ===== rtl/kdda_pkg.sv =====
package kdda_pkg;

    localparam int MAX_KMER_LEN_DEF = 32;
    localparam int FRAC_BITS_DEF    = 16;

    localparam int LOG_FRAC   = 26;
    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS  = 62;

    localparam logic [63:0] NORM_MAX      = 64'h3FFF_FFFF_FFFF_FFFF;
    localparam logic [31:0] INV_SQRT2_Q32 = 32'd3037000500;
    localparam logic [31:0] LN2_Q28       = 32'd186065279;

    localparam logic [63:0] FREQS_RESET   = 64'h4000_4000_4000_4000;
    localparam logic [5:0]  KMER_RESET    = 6'd21;
    localparam logic [31:0] SEQS_RESET    = 32'd1;
    localparam logic [39:0] TOTAL_RESET   = 40'd0;

    // Configuration register indexes
    localparam logic [2:0] REG_FREQS_FIRST  = 3'd0;
    localparam logic [2:0] REG_FREQS_SECOND = 3'd1;
    localparam logic [2:0] REG_KMER_LEN     = 3'd2;
    localparam logic [2:0] REG_SEQS_FIRST   = 3'd3;
    localparam logic [2:0] REG_SEQS_SECOND  = 3'd4;
    localparam logic [2:0] REG_TOTAL_FIRST  = 3'd5;
    localparam logic [2:0] REG_TOTAL_SECOND = 3'd6;

    // Log operand select
    localparam logic [1:0] LOG_SRC_CROSS  = 2'd0;
    localparam logic [1:0] LOG_SRC_FIRST  = 2'd1;
    localparam logic [1:0] LOG_SRC_SECOND = 2'd2;

    typedef enum logic [4:0] {
        OP_NOP, OP_PINIT, OP_PSTEP, OP_SPAN, OP_LEN, OP_ELO, OP_EHI, OP_MAG,
        OP_SLO, OP_SHI, OP_XLOAD, OP_XSHIFT, OP_XAA, OP_XBB, OP_XAB, OP_SQRT,
        OP_DIV, OP_XACC, OP_LGLOAD, OP_LGNORM, OP_LGY, OP_LGSQ, OP_LGACC, OP_FIN
    } op_t;

    typedef enum logic [4:0] {
        ST_IDLE, ST_DISPATCH, ST_PINIT, ST_PSTEP, ST_SPAN, ST_LEN, ST_ELO,
        ST_EHI, ST_MAG, ST_SLO, ST_SHI, ST_XLOAD, ST_XSHIFT, ST_XAA, ST_XBB,
        ST_XAB, ST_SQRT, ST_DIV, ST_XACC, ST_CHECK, ST_LGLOAD, ST_LGNORM,
        ST_LGY, ST_LGSQ, ST_LGACC, ST_FIN
    } state_t;

    typedef struct packed {
        op_t        op;
        logic       sel;
        logic [1:0] lsel;
        logic       in_ready;
    } cmd_t;

    typedef struct packed {
        logic       nz_first;
        logic       nz_second;
        logic       last;
        logic [5:0] k_eff;
        logic       x_shift;
        logic       x_zero;
        logic       lg_shift;
        logic       undef;
        logic       out_busy;
    } status_t;

endpackage

// ===== rtl/kmer_d2s_distance_accumulator_unit.sv =====
// One record at a time through a shared 34x32 multiplier and bit-serial root/divide loops.
// Each sample with a nonzero count runs a product loop over its k bases; when both counts
// are nonzero, both magnitudes are shifted below 2^31 and, unless one is then zero, squared,
// rooted and divided. The last record then takes three logs when the result is defined.
// The result is registered at the final step; a held earlier result stalls only that step.
// Reset (rst_n low, async) clears sums, control and output valid and loads config defaults.
module kmer_d2s_distance_accumulator_unit #(
    parameter int MAX_KMER_LEN = kdda_pkg::MAX_KMER_LEN_DEF,
    parameter int FRAC_BITS    = kdda_pkg::FRAC_BITS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_wr_en,
    input  logic [2:0]   cfg_addr,
    input  logic [63:0]  cfg_wdata,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,  // kmer_bases[63:0], count_first, count_second
    input  logic         s_axis_tlast,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [31:0]  m_axis_tdata,  // distance
    output logic         m_axis_tuser   // undefined_result
);

    kdda_pkg::cmd_t    cmd;
    kdda_pkg::status_t status;

    assign s_axis_tready = cmd.in_ready;

    kdda_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .status   (status),
        .cmd      (cmd)
    );

    kdda_datapath #(
        .MAX_KMER_LEN (MAX_KMER_LEN),
        .FRAC_BITS    (FRAC_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .in_valid  (s_axis_tvalid),
        .in_data   (s_axis_tdata),
        .in_last   (s_axis_tlast),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .out_user  (m_axis_tuser)
    );

endmodule

// ===== rtl/kdda_ctrl.sv =====
module kdda_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  kdda_pkg::status_t status,
    output kdda_pkg::cmd_t    cmd
);

    kdda_pkg::state_t state_reg, state_next;
    logic [5:0]       cnt_reg, cnt_next;
    logic             sel_reg, sel_next;
    logic [1:0]       lsel_reg, lsel_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= kdda_pkg::ST_IDLE;
            cnt_reg   <= '0;
            sel_reg   <= 1'b0;
            lsel_reg  <= kdda_pkg::LOG_SRC_CROSS;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            sel_reg   <= sel_next;
            lsel_reg  <= lsel_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        sel_next     = sel_reg;
        lsel_next    = lsel_reg;
        cmd.op       = kdda_pkg::OP_NOP;
        cmd.sel      = sel_reg;
        cmd.lsel     = lsel_reg;
        cmd.in_ready = 1'b0;
        case (state_reg)
            kdda_pkg::ST_IDLE:
            begin
                cmd.in_ready = 1'b1;
                if (in_valid)
                    state_next = kdda_pkg::ST_DISPATCH;
            end
            kdda_pkg::ST_DISPATCH:
            begin
                if (status.nz_first)
                begin
                    sel_next   = 1'b0;
                    state_next = kdda_pkg::ST_PINIT;
                end
                else if (status.nz_second)
                begin
                    sel_next   = 1'b1;
                    state_next = kdda_pkg::ST_PINIT;
                end
                else
                    state_next = kdda_pkg::ST_CHECK;
            end
            kdda_pkg::ST_PINIT:
            begin
                cmd.op     = kdda_pkg::OP_PINIT;
                cnt_next   = status.k_eff - 6'd1;
                state_next = kdda_pkg::ST_PSTEP;
            end
            kdda_pkg::ST_PSTEP:
            begin
                cmd.op = kdda_pkg::OP_PSTEP;
                if (cnt_reg == '0)
                    state_next = kdda_pkg::ST_SPAN;
                else
                    cnt_next = cnt_reg - 6'd1;
            end
            kdda_pkg::ST_SPAN:
            begin
                cmd.op     = kdda_pkg::OP_SPAN;
                state_next = kdda_pkg::ST_LEN;
            end
            kdda_pkg::ST_LEN:
            begin
                cmd.op     = kdda_pkg::OP_LEN;
                state_next = kdda_pkg::ST_ELO;
            end
            kdda_pkg::ST_ELO:
            begin
                cmd.op     = kdda_pkg::OP_ELO;
                state_next = kdda_pkg::ST_EHI;
            end
            kdda_pkg::ST_EHI:
            begin
                cmd.op     = kdda_pkg::OP_EHI;
                state_next = kdda_pkg::ST_MAG;
            end
            kdda_pkg::ST_MAG:
            begin
                cmd.op     = kdda_pkg::OP_MAG;
                state_next = kdda_pkg::ST_SLO;
            end
            kdda_pkg::ST_SLO:
            begin
                cmd.op     = kdda_pkg::OP_SLO;
                state_next = kdda_pkg::ST_SHI;
            end
            kdda_pkg::ST_SHI:
            begin
                cmd.op = kdda_pkg::OP_SHI;
                if (!sel_reg && status.nz_second)
                begin
                    sel_next   = 1'b1;
                    state_next = kdda_pkg::ST_PINIT;
                end
                else if (status.nz_first && status.nz_second)
                    state_next = kdda_pkg::ST_XLOAD;
                else
                    state_next = kdda_pkg::ST_CHECK;
            end
            kdda_pkg::ST_XLOAD:
            begin
                cmd.op     = kdda_pkg::OP_XLOAD;
                state_next = kdda_pkg::ST_XSHIFT;
            end
            kdda_pkg::ST_XSHIFT:
            begin
                // scale both magnitudes below 2^31 before squaring
                if (status.x_shift)
                    cmd.op = kdda_pkg::OP_XSHIFT;
                else if (status.x_zero)
                    state_next = kdda_pkg::ST_CHECK;
                else
                    state_next = kdda_pkg::ST_XAA;
            end
            kdda_pkg::ST_XAA:
            begin
                cmd.op     = kdda_pkg::OP_XAA;
                state_next = kdda_pkg::ST_XBB;
            end
            kdda_pkg::ST_XBB:
            begin
                cmd.op     = kdda_pkg::OP_XBB;
                state_next = kdda_pkg::ST_XAB;
            end
            kdda_pkg::ST_XAB:
            begin
                cmd.op     = kdda_pkg::OP_XAB;
                cnt_next   = 6'(kdda_pkg::SQRT_STEPS - 1);
                state_next = kdda_pkg::ST_SQRT;
            end
            kdda_pkg::ST_SQRT:
            begin
                cmd.op = kdda_pkg::OP_SQRT;
                if (cnt_reg == '0)
                begin
                    cnt_next   = 6'(kdda_pkg::DIV_STEPS - 1);
                    state_next = kdda_pkg::ST_DIV;
                end
                else
                    cnt_next = cnt_reg - 6'd1;
            end
            kdda_pkg::ST_DIV:
            begin
                cmd.op = kdda_pkg::OP_DIV;
                if (cnt_reg == '0)
                    state_next = kdda_pkg::ST_XACC;
                else
                    cnt_next = cnt_reg - 6'd1;
            end
            kdda_pkg::ST_XACC:
            begin
                cmd.op     = kdda_pkg::OP_XACC;
                state_next = kdda_pkg::ST_CHECK;
            end
            kdda_pkg::ST_CHECK:
            begin
                if (!status.last)
                    state_next = kdda_pkg::ST_IDLE;
                else if (status.undef)
                    state_next = kdda_pkg::ST_FIN;
                else
                begin
                    lsel_next  = kdda_pkg::LOG_SRC_CROSS;
                    state_next = kdda_pkg::ST_LGLOAD;
                end
            end
            kdda_pkg::ST_LGLOAD:
            begin
                cmd.op     = kdda_pkg::OP_LGLOAD;
                state_next = kdda_pkg::ST_LGNORM;
            end
            kdda_pkg::ST_LGNORM:
            begin
                if (status.lg_shift)
                    cmd.op = kdda_pkg::OP_LGNORM;
                else
                    state_next = kdda_pkg::ST_LGY;
            end
            kdda_pkg::ST_LGY:
            begin
                cmd.op     = kdda_pkg::OP_LGY;
                cnt_next   = 6'(kdda_pkg::LOG_FRAC - 1);
                state_next = kdda_pkg::ST_LGSQ;
            end
            kdda_pkg::ST_LGSQ:
            begin
                cmd.op = kdda_pkg::OP_LGSQ;
                if (cnt_reg == '0)
                    state_next = kdda_pkg::ST_LGACC;
                else
                    cnt_next = cnt_reg - 6'd1;
            end
            kdda_pkg::ST_LGACC:
            begin
                cmd.op = kdda_pkg::OP_LGACC;
                if (lsel_reg == kdda_pkg::LOG_SRC_SECOND)
                    state_next = kdda_pkg::ST_FIN;
                else
                begin
                    lsel_next  = lsel_reg + 2'd1;
                    state_next = kdda_pkg::ST_LGLOAD;
                end
            end
            kdda_pkg::ST_FIN:
            begin
                // hold until the output register is free
                if (!status.out_busy)
                begin
                    cmd.op     = kdda_pkg::OP_FIN;
                    state_next = kdda_pkg::ST_IDLE;
                end
            end
            default:
                state_next = kdda_pkg::ST_IDLE;
        endcase
    end

endmodule

// ===== rtl/kdda_datapath.sv =====
module kdda_datapath #(
    parameter int MAX_KMER_LEN = kdda_pkg::MAX_KMER_LEN_DEF,
    parameter int FRAC_BITS    = kdda_pkg::FRAC_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  kdda_pkg::cmd_t    cmd,
    output kdda_pkg::status_t status,
    input  logic              cfg_wr_en,
    input  logic [2:0]        cfg_addr,
    input  logic [63:0]       cfg_wdata,
    input  logic              in_valid,
    input  logic [127:0]      in_data,
    input  logic              in_last,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [31:0]       out_data,
    output logic              out_user
);

    localparam int SH = 32 - FRAC_BITS;

    // configuration
    logic [63:0] freqs_first_reg, freqs_second_reg;
    logic [5:0]  kmer_len_reg;
    logic [31:0] seqs_first_reg, seqs_second_reg;
    logic [39:0] total_first_reg, total_second_reg;

    // record
    logic [63:0] bases_reg;
    logic [31:0] count_first_reg, count_second_reg;
    logic        last_reg;

    // work registers
    logic [63:0] bases_sh_reg, bases_sh_next;
    logic [32:0] p_reg, p_next;
    logic [36:0] span_reg, span_next;
    logic [39:0] len_reg, len_next;
    logic        len_neg_reg, len_neg_next;
    logic [95:0] acc_reg, acc_next;
    logic [61:0] mag_first_reg, mag_first_next, mag_second_reg, mag_second_next;
    logic        neg_first_reg, neg_first_next, neg_second_reg, neg_second_next;
    logic [61:0] a_reg, a_next, b_reg, b_next;
    logic [5:0]  s_reg, s_next;
    logic [62:0] rad_reg, rad_next;
    logic [62:0] res_reg, res_next;
    logic [62:0] bit_reg, bit_next;
    logic [61:0] ab_reg, ab_next;
    logic [32:0] rem_reg, rem_next;
    logic [63:0] lx_reg, lx_next;
    logic [5:0]  lm_reg, lm_next;
    logic [30:0] y_reg, y_next;
    logic [25:0] frac_reg, frac_next;

    // sums and output
    logic [63:0] self_first_reg, self_first_next, self_second_reg, self_second_next;
    logic [63:0] cross_reg, cross_next;
    logic [35:0] d_reg, d_next;
    logic        out_valid_reg, out_valid_next;
    logic [31:0] out_data_reg, out_data_next;
    logic        out_user_reg, out_user_next;

    // shared multiplier
    logic [33:0] mul_a;
    logic [31:0] mul_b;
    logic [65:0] prod;

    logic [63:0] freqs_cur;
    logic [31:0] seqs_cur, count_cur;
    logic [39:0] total_cur;
    logic [61:0] mag_cur;
    logic [5:0]  k_eff;
    logic [15:0] freq;
    logic [63:0] e_val, cf, mag64;
    logic        mag_neg;
    logic [95:0] term_sum;
    logic [64:0] self_sum;
    logic [62:0] sq_try;
    logic [32:0] rem_try;
    logic [63:0] xterm;
    logic [64:0] cross_wide;
    logic [31:0] yy;
    logic [31:0] lg_val;
    logic [35:0] d_mag;
    logic [66:0] rnd;
    logic [35:0] dist_full;

    assign prod = 66'(mul_a) * 66'(mul_b);

    assign freqs_cur = cmd.sel ? freqs_second_reg : freqs_first_reg;
    assign seqs_cur  = cmd.sel ? seqs_second_reg  : seqs_first_reg;
    assign total_cur = cmd.sel ? total_second_reg : total_first_reg;
    assign count_cur = cmd.sel ? count_second_reg : count_first_reg;
    assign mag_cur   = cmd.sel ? mag_second_reg   : mag_first_reg;
    assign freq      = freqs_cur[{bases_sh_reg[1:0], 4'b0000} +: 16];

    always_comb
    begin
        if (kmer_len_reg == '0)
            k_eff = 6'd1;
        else if (kmer_len_reg > 6'(MAX_KMER_LEN))
            k_eff = 6'(MAX_KMER_LEN);
        else
            k_eff = kmer_len_reg;
    end

    assign status.nz_first  = (count_first_reg != '0);
    assign status.nz_second = (count_second_reg != '0);
    assign status.last      = last_reg;
    assign status.k_eff     = k_eff;
    assign status.x_shift   = |(a_reg[61:31] | b_reg[61:31]);
    assign status.x_zero    = (a_reg == '0) || (b_reg == '0);
    assign status.lg_shift  = !lx_reg[63] && (lm_reg != '0);
    assign status.undef     = cross_reg[63] || (cross_reg == '0) ||
                              (self_first_reg == '0) || (self_second_reg == '0);
    assign status.out_busy  = out_valid_reg;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_user  = out_user_reg;

    always_comb
    begin
        bases_sh_next    = bases_sh_reg;
        p_next           = p_reg;
        span_next        = span_reg;
        len_next         = len_reg;
        len_neg_next     = len_neg_reg;
        acc_next         = acc_reg;
        mag_first_next   = mag_first_reg;
        mag_second_next  = mag_second_reg;
        neg_first_next   = neg_first_reg;
        neg_second_next  = neg_second_reg;
        a_next           = a_reg;
        b_next           = b_reg;
        s_next           = s_reg;
        rad_next         = rad_reg;
        res_next         = res_reg;
        bit_next         = bit_reg;
        ab_next          = ab_reg;
        rem_next         = rem_reg;
        lx_next          = lx_reg;
        lm_next          = lm_reg;
        y_next           = y_reg;
        frac_next        = frac_reg;
        self_first_next  = self_first_reg;
        self_second_next = self_second_reg;
        cross_next       = cross_reg;
        d_next           = d_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        out_data_next    = out_data_reg;
        out_user_next    = out_user_reg;
        mul_a            = '0;
        mul_b            = '0;
        e_val            = acc_reg[SH +: 64];
        cf               = 64'(count_cur) << FRAC_BITS;
        mag64            = '0;
        mag_neg          = 1'b0;
        term_sum         = '0;
        self_sum         = '0;
        sq_try           = res_reg + bit_reg;
        rem_try          = {rem_reg[31:0], ab_reg[61]};
        xterm            = 64'(ab_reg[30:0]) << s_reg;
        cross_wide       = '0;
        yy               = '0;
        lg_val           = {lm_reg, frac_reg};
        d_mag            = d_reg[35] ? (36'd0 - d_reg) : d_reg;
        rnd              = '0;
        dist_full        = '0;
        case (cmd.op)
            kdda_pkg::OP_NOP:
            begin
            end
            kdda_pkg::OP_PINIT:
            begin
                p_next        = 33'h1_0000_0000;
                bases_sh_next = bases_reg;
            end
            kdda_pkg::OP_PSTEP:
            begin
                mul_a         = {1'b0, p_reg};
                mul_b         = {16'd0, freq};
                p_next        = prod[48:16];
                bases_sh_next = bases_sh_reg >> 2;
            end
            kdda_pkg::OP_SPAN:
            begin
                mul_a     = 34'(k_eff - 6'd1);
                mul_b     = seqs_cur;
                span_next = prod[36:0];
            end
            kdda_pkg::OP_LEN:
            begin
                if (total_cur >= 40'(span_reg))
                begin
                    len_neg_next = 1'b0;
                    len_next     = total_cur - 40'(span_reg);
                end
                else
                begin
                    len_neg_next = 1'b1;
                    len_next     = 40'(span_reg) - total_cur;
                end
            end
            kdda_pkg::OP_ELO:
            begin
                mul_a    = {1'b0, p_reg};
                mul_b    = {12'd0, len_reg[19:0]};
                acc_next = 96'(prod[52:0]);
            end
            kdda_pkg::OP_EHI:
            begin
                mul_a    = {1'b0, p_reg};
                mul_b    = {12'd0, len_reg[39:20]};
                acc_next = acc_reg + (96'(prod[52:0]) << 20);
            end
            kdda_pkg::OP_MAG:
            begin
                if (len_neg_reg)
                    mag64 = cf + e_val;
                else if (cf >= e_val)
                    mag64 = cf - e_val;
                else
                begin
                    mag64   = e_val - cf;
                    mag_neg = 1'b1;
                end
                if (mag64 > kdda_pkg::NORM_MAX)
                    mag64 = kdda_pkg::NORM_MAX;
                if (cmd.sel)
                begin
                    mag_second_next = mag64[61:0];
                    neg_second_next = mag_neg;
                end
                else
                begin
                    mag_first_next = mag64[61:0];
                    neg_first_next = mag_neg;
                end
            end
            kdda_pkg::OP_SLO:
            begin
                mul_a    = {3'd0, mag_cur[30:0]};
                mul_b    = kdda_pkg::INV_SQRT2_Q32;
                acc_next = 96'(prod[62:0]);
            end
            kdda_pkg::OP_SHI:
            begin
                mul_a    = {3'd0, mag_cur[61:31]};
                mul_b    = kdda_pkg::INV_SQRT2_Q32;
                term_sum = acc_reg + (96'(prod[62:0]) << 31);
                if (cmd.sel)
                    self_sum = {1'b0, self_second_reg} + {1'b0, term_sum[95:32]};
                else
                    self_sum = {1'b0, self_first_reg} + {1'b0, term_sum[95:32]};
                // saturate on carry out
                if (self_sum[64])
                    self_sum[63:0] = '1;
                if (cmd.sel)
                    self_second_next = self_sum[63:0];
                else
                    self_first_next = self_sum[63:0];
            end
            kdda_pkg::OP_XLOAD:
            begin
                a_next = mag_first_reg;
                b_next = mag_second_reg;
                s_next = '0;
            end
            kdda_pkg::OP_XSHIFT:
            begin
                a_next = a_reg >> 1;
                b_next = b_reg >> 1;
                s_next = s_reg + 6'd1;
            end
            kdda_pkg::OP_XAA:
            begin
                mul_a    = {3'd0, a_reg[30:0]};
                mul_b    = {1'b0, a_reg[30:0]};
                acc_next = 96'(prod[61:0]);
            end
            kdda_pkg::OP_XBB:
            begin
                mul_a    = {3'd0, b_reg[30:0]};
                mul_b    = {1'b0, b_reg[30:0]};
                rad_next = 63'(acc_reg[61:0]) + 63'(prod[61:0]);
            end
            kdda_pkg::OP_XAB:
            begin
                mul_a    = {3'd0, a_reg[30:0]};
                mul_b    = {1'b0, b_reg[30:0]};
                ab_next  = prod[61:0];
                res_next = '0;
                bit_next = 63'(1) << 62;
                rem_next = '0;
            end
            kdda_pkg::OP_SQRT:
            begin
                if (rad_reg >= sq_try)
                begin
                    rad_next = rad_reg - sq_try;
                    res_next = (res_reg >> 1) + bit_reg;
                end
                else
                    res_next = res_reg >> 1;
                bit_next = bit_reg >> 2;
            end
            kdda_pkg::OP_DIV:
            begin
                // restoring divide of the product by the root, one bit per step
                if (rem_try >= {1'b0, res_reg[31:0]})
                begin
                    rem_next = rem_try - {1'b0, res_reg[31:0]};
                    ab_next  = {ab_reg[60:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_try;
                    ab_next  = {ab_reg[60:0], 1'b0};
                end
            end
            kdda_pkg::OP_XACC:
            begin
                if (neg_first_reg != neg_second_reg)
                    cross_wide = {cross_reg[63], cross_reg} - {1'b0, xterm};
                else
                    cross_wide = {cross_reg[63], cross_reg} + {1'b0, xterm};
                if (cross_wide[64] != cross_wide[63])
                    cross_next = cross_wide[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
                else
                    cross_next = cross_wide[63:0];
            end
            kdda_pkg::OP_LGLOAD:
            begin
                case (cmd.lsel)
                    kdda_pkg::LOG_SRC_CROSS:  lx_next = cross_reg;
                    kdda_pkg::LOG_SRC_FIRST:  lx_next = self_first_reg;
                    default:                  lx_next = self_second_reg;
                endcase
                lm_next = 6'd63;
            end
            kdda_pkg::OP_LGNORM:
            begin
                lx_next = lx_reg << 1;
                lm_next = lm_reg - 6'd1;
            end
            kdda_pkg::OP_LGY:
            begin
                y_next    = lx_reg[63:33];
                frac_next = '0;
            end
            kdda_pkg::OP_LGSQ:
            begin
                mul_a = {3'd0, y_reg};
                mul_b = {1'b0, y_reg};
                yy    = prod[61:30];
                if (yy[31])
                begin
                    y_next    = yy[31:1];
                    frac_next = {frac_reg[24:0], 1'b1};
                end
                else
                begin
                    y_next    = yy[30:0];
                    frac_next = {frac_reg[24:0], 1'b0};
                end
            end
            kdda_pkg::OP_LGACC:
            begin
                if (cmd.lsel == kdda_pkg::LOG_SRC_CROSS)
                    d_next = d_reg + (36'(lg_val) << 1);
                else
                    d_next = d_reg - 36'(lg_val);
            end
            kdda_pkg::OP_FIN:
            begin
                mul_a     = d_mag[33:0];
                mul_b     = kdda_pkg::LN2_Q28;
                rnd       = 67'(prod) + (67'(1) << 30);
                dist_full = rnd[66:31];
                if (status.undef)
                begin
                    out_data_next = '0;
                    out_user_next = 1'b1;
                end
                else
                begin
                    out_data_next = (dist_full[35:32] != '0) ? 32'hFFFF_FFFF : dist_full[31:0];
                    out_user_next = 1'b0;
                end
                out_valid_next   = 1'b1;
                self_first_next  = '0;
                self_second_next = '0;
                cross_next       = '0;
                d_next           = '0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            freqs_first_reg  <= kdda_pkg::FREQS_RESET;
            freqs_second_reg <= kdda_pkg::FREQS_RESET;
            kmer_len_reg     <= kdda_pkg::KMER_RESET;
            seqs_first_reg   <= kdda_pkg::SEQS_RESET;
            seqs_second_reg  <= kdda_pkg::SEQS_RESET;
            total_first_reg  <= kdda_pkg::TOTAL_RESET;
            total_second_reg <= kdda_pkg::TOTAL_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_addr)
                kdda_pkg::REG_FREQS_FIRST:  freqs_first_reg  <= cfg_wdata;
                kdda_pkg::REG_FREQS_SECOND: freqs_second_reg <= cfg_wdata;
                kdda_pkg::REG_KMER_LEN:     kmer_len_reg     <= cfg_wdata[5:0];
                kdda_pkg::REG_SEQS_FIRST:   seqs_first_reg   <= cfg_wdata[31:0];
                kdda_pkg::REG_SEQS_SECOND:  seqs_second_reg  <= cfg_wdata[31:0];
                kdda_pkg::REG_TOTAL_FIRST:  total_first_reg  <= cfg_wdata[39:0];
                kdda_pkg::REG_TOTAL_SECOND: total_second_reg <= cfg_wdata[39:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            self_first_reg  <= '0;
            self_second_reg <= '0;
            cross_reg       <= '0;
            d_reg           <= '0;
            out_valid_reg   <= 1'b0;
            last_reg        <= 1'b0;
            count_first_reg <= '0;
            count_second_reg <= '0;
        end
        else
        begin
            self_first_reg  <= self_first_next;
            self_second_reg <= self_second_next;
            cross_reg       <= cross_next;
            d_reg           <= d_next;
            out_valid_reg   <= out_valid_next;
            if (in_valid && cmd.in_ready)
            begin
                last_reg         <= in_last;
                count_first_reg  <= in_data[95:64];
                count_second_reg <= in_data[127:96];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && cmd.in_ready)
            bases_reg <= in_data[63:0];
        bases_sh_reg   <= bases_sh_next;
        p_reg          <= p_next;
        span_reg       <= span_next;
        len_reg        <= len_next;
        len_neg_reg    <= len_neg_next;
        acc_reg        <= acc_next;
        mag_first_reg  <= mag_first_next;
        mag_second_reg <= mag_second_next;
        neg_first_reg  <= neg_first_next;
        neg_second_reg <= neg_second_next;
        a_reg          <= a_next;
        b_reg          <= b_next;
        s_reg          <= s_next;
        rad_reg        <= rad_next;
        res_reg        <= res_next;
        bit_reg        <= bit_next;
        ab_reg         <= ab_next;
        rem_reg        <= rem_next;
        lx_reg         <= lx_next;
        lm_reg         <= lm_next;
        y_reg          <= y_next;
        frac_reg       <= frac_next;
        out_data_reg   <= out_data_next;
        out_user_reg   <= out_user_next;
    end

endmodule

// ===== rtl/kdda_checker.sv =====
`include "kmer_d2s_distance_accumulator_unit_defines.svh"

module kdda_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [31:0]  m_axis_tdata,
    input logic         m_axis_tuser
);

    // result held while stalled
    `KDDA_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
    `KDDA_ASSERT_NEXT(a_out_stable, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))
    // one record in work at a time
    `KDDA_ASSERT_NEXT(a_busy_after_in, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    // undefined result carries zero distance
    `KDDA_ASSERT_SAME(a_undef_zero, m_axis_tvalid && m_axis_tuser, m_axis_tdata == 32'd0)

endmodule

bind kmer_d2s_distance_accumulator_unit kdda_checker u_kdda_checker (.*);

// ===== tb/kdda_checker.sv =====
`timescale 1ns / 100ps

module kdda_scoreboard (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_wr_en,
    input  logic [2:0]   cfg_addr,
    input  logic [63:0]  cfg_wdata,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,
    input  logic         s_axis_tlast,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [31:0]  m_axis_tdata,
    input  logic         m_axis_tuser,
    output int           mismatch_count,
    output int           distances_pending
);

    typedef struct {
        logic [31:0] distance;
        logic        undefined;
    } distance_t;

    distance_t expected_distances[$];

    logic [63:0] freqs_a, freqs_b;
    logic [5:0]  kmer_len;
    logic [31:0] seqs_a, seqs_b;
    logic [39:0] total_a, total_b;

    logic signed [63:0] cross_acc;
    logic [63:0]        self_acc_a, self_acc_b;

    assign distances_pending = expected_distances.size();

    function automatic logic [63:0] isqrt64(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] probe;
        res = 0;
        probe = 64'd1 << 62;
        while (probe > v)
            probe = probe >> 2;
        while (probe != 0)
        begin
            if (v >= res + probe)
            begin
                v = v - (res + probe);
                res = (res >> 1) + probe;
            end
            else
                res = res >> 1;
            probe = probe >> 2;
        end
        return res;
    endfunction

    function automatic logic [63:0] log2_q26(input logic [63:0] x);
        int          m;
        logic [63:0] y;
        logic [63:0] frac;
        m = 63;
        frac = 0;
        while (x[m] == 1'b0 && m > 0)
            m--;
        y = (m >= 30) ? (x >> (m - 30)) : (x << (30 - m));
        for (int i = 0; i < kdda_pkg::LOG_FRAC; i++)
        begin
            y = (y * y) >> 30;
            frac = frac << 1;
            if (y >= (64'd2 << 30))
            begin
                y = y >> 1;
                frac = frac | 64'd1;
            end
        end
        return (64'(m) << kdda_pkg::LOG_FRAC) | frac;
    endfunction

    // Observed minus expected count for one sample, as magnitude and sign.
    function automatic logic [63:0] deviation(input logic [31:0] count,
                                              input logic [63:0] freqs,
                                              input logic [39:0] total,
                                              input logic [31:0] seqs,
                                              input int k, input logic [63:0] bases,
                                              output logic neg);
        logic [63:0]  p;
        logic [63:0]  span;
        logic [63:0]  len;
        logic [127:0] prod;
        logic [63:0]  e;
        logic [63:0]  cf;
        logic [63:0]  mag;
        logic         len_neg;
        p = 64'd1 << 32;
        for (int i = 0; i < k; i++)
            p = (p * 64'(freqs[16 * bases[2 * i +: 2] +: 16])) >> 16;
        span = 64'(seqs) * 64'(k - 1);
        len_neg = 64'(total) < span;
        len = len_neg ? span - 64'(total) : 64'(total) - span;
        prod = 128'(p) * 128'(len);
        e = prod[16 +: 64];
        cf = 64'(count) << 16;
        neg = 1'b0;
        if (len_neg)
            mag = cf + e;
        else if (cf >= e)
            mag = cf - e;
        else
        begin
            mag = e - cf;
            neg = 1'b1;
        end
        if (mag > kdda_pkg::NORM_MAX)
            mag = kdda_pkg::NORM_MAX;
        return mag;
    endfunction

    function automatic logic [63:0] self_increment(input logic [63:0] mag);
        logic [127:0] prod;
        prod = 128'(mag) * 128'(kdda_pkg::INV_SQRT2_Q32);
        return prod[32 +: 64];
    endfunction

    function automatic logic [63:0] cross_increment(input logic [63:0] a, input logic [63:0] b);
        int          s;
        logic [63:0] r;
        s = 0;
        while (((a >> s) | (b >> s)) >= (64'd1 << 31))
            s++;
        a = a >> s;
        b = b >> s;
        if (a == 0 || b == 0)
            return 0;
        r = isqrt64(a * a + b * b);
        if (r == 0)
            return 0;
        return ((a * b) / r) << s;
    endfunction

    function automatic logic [63:0] add_sat_u(input logic [63:0] x, input logic [63:0] y);
        logic [64:0] sum;
        sum = 65'(x) + 65'(y);
        return sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : sum[63:0];
    endfunction

    // Accumulate one record; returns 1 with a distance when it closes the set.
    function automatic bit accumulate_record(input logic [127:0] rec, input logic last,
                                             output distance_t res);
        logic [63:0]        bases;
        logic [31:0]        c1, c2;
        logic [63:0]        m1, m2, t;
        logic               n1, n2;
        logic signed [64:0] acc;
        logic signed [63:0] d;
        logic [63:0]        dmag, v;
        int                 k;
        bases = rec[63:0];
        c1 = rec[95:64];
        c2 = rec[127:96];
        k = int'(kmer_len);
        m1 = 0;
        m2 = 0;
        n1 = 1'b0;
        n2 = 1'b0;
        if (k < 1)
            k = 1;
        if (k > kdda_pkg::MAX_KMER_LEN_DEF)
            k = kdda_pkg::MAX_KMER_LEN_DEF;
        if (c1 != 0)
        begin
            m1 = deviation(c1, freqs_a, total_a, seqs_a, k, bases, n1);
            self_acc_a = add_sat_u(self_acc_a, self_increment(m1));
        end
        if (c2 != 0)
        begin
            m2 = deviation(c2, freqs_b, total_b, seqs_b, k, bases, n2);
            self_acc_b = add_sat_u(self_acc_b, self_increment(m2));
        end
        if (c1 != 0 && c2 != 0)
        begin
            t = cross_increment(m1, m2);
            acc = (n1 != n2) ? 65'(cross_acc) - 65'($signed({1'b0, t}))
                             : 65'(cross_acc) + 65'($signed({1'b0, t}));
            if (acc > 65'sh0_7FFF_FFFF_FFFF_FFFF)
                cross_acc = 64'sh7FFF_FFFF_FFFF_FFFF;
            else if (acc < -65'sh0_8000_0000_0000_0000)
                cross_acc = 64'sh8000_0000_0000_0000;
            else
                cross_acc = acc[63:0];
        end
        if (!last)
            return 0;
        if (cross_acc <= 0 || self_acc_a == 0 || self_acc_b == 0)
        begin
            res.distance = 0;
            res.undefined = 1'b1;
        end
        else
        begin
            d = $signed(2 * log2_q26(cross_acc)) - $signed(log2_q26(self_acc_a))
                - $signed(log2_q26(self_acc_b));
            dmag = (d < 0) ? -d : d;
            v = (dmag * 64'(kdda_pkg::LN2_Q28) + (64'd1 << 30)) >> 31;
            res.distance = (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
            res.undefined = 1'b0;
        end
        cross_acc = 0;
        self_acc_a = 0;
        self_acc_b = 0;
        return 1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        distance_t exp_d;
        if (!rst_n)
        begin
            freqs_a = kdda_pkg::FREQS_RESET;
            freqs_b = kdda_pkg::FREQS_RESET;
            kmer_len = kdda_pkg::KMER_RESET;
            seqs_a = kdda_pkg::SEQS_RESET;
            seqs_b = kdda_pkg::SEQS_RESET;
            total_a = kdda_pkg::TOTAL_RESET;
            total_b = kdda_pkg::TOTAL_RESET;
            cross_acc = 0;
            self_acc_a = 0;
            self_acc_b = 0;
            mismatch_count = 0;
            expected_distances.delete();
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_addr)
                    kdda_pkg::REG_FREQS_FIRST:  freqs_a = cfg_wdata;
                    kdda_pkg::REG_FREQS_SECOND: freqs_b = cfg_wdata;
                    kdda_pkg::REG_KMER_LEN:     kmer_len = cfg_wdata[5:0];
                    kdda_pkg::REG_SEQS_FIRST:   seqs_a = cfg_wdata[31:0];
                    kdda_pkg::REG_SEQS_SECOND:  seqs_b = cfg_wdata[31:0];
                    kdda_pkg::REG_TOTAL_FIRST:  total_a = cfg_wdata[39:0];
                    kdda_pkg::REG_TOTAL_SECOND: total_b = cfg_wdata[39:0];
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                if (accumulate_record(s_axis_tdata, s_axis_tlast, exp_d))
                    expected_distances.push_back(exp_d);
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_distances.size() == 0)
                begin
                    $error("unexpected result transfer: distance %0d undefined %0d",
                           m_axis_tdata, m_axis_tuser);
                    mismatch_count++;
                end
                else
                begin
                    exp_d = expected_distances.pop_front();
                    if (m_axis_tdata !== exp_d.distance)
                    begin
                        $error("distance: expected %0d actual %0d", exp_d.distance,
                               m_axis_tdata);
                        mismatch_count++;
                    end
                    if (m_axis_tuser !== exp_d.undefined)
                    begin
                        $error("undefined_result: expected %0d actual %0d",
                               exp_d.undefined, m_axis_tuser);
                        mismatch_count++;
                    end
                end
            end
        end
    end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

    localparam int DRAIN_CYCLES = 800;
    localparam int CYCLE_LIMIT  = 4000000;

    logic         clk;
    logic         rst_n;
    logic         cfg_wr_en;
    logic [2:0]   cfg_addr;
    logic [63:0]  cfg_wdata;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata;  // kmer_bases[63:0], count_first, count_second
    logic         s_axis_tlast;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [31:0]  m_axis_tdata;  // distance
    logic         m_axis_tuser;  // undefined_result

    int mismatch_count;
    int distances_pending;
    int sender_idle_pct;
    int receiver_stall_pct;
    int cycle_count;

    kmer_d2s_distance_accumulator_unit uut (
        .clk(clk), .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
    );

    kdda_scoreboard distance_checker (
        .clk(clk), .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .mismatch_count(mismatch_count), .distances_pending(distances_pending)
    );

    initial
    begin
        clk = 1'b0;
        m_axis_tready = 1'b0;
    end

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(negedge clk)
        m_axis_tready <= ($urandom_range(99) >= receiver_stall_pct);

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
        @(negedge clk);
        cfg_wr_en = 1'b1;
        cfg_addr = idx;
        cfg_wdata = value;
        @(negedge clk);
        cfg_wr_en = 1'b0;
    endtask

    // Hold until every distance is out, then let any record still in flight finish.
    task automatic drain_distances();
        while (distances_pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic send_record(input logic [63:0] bases, input logic [31:0] c1,
                               input logic [31:0] c2, input logic last);
        s_axis_tdata = {c2, c1, bases};
        s_axis_tlast = last;
        s_axis_tvalid = 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        @(negedge clk);
        if ($urandom_range(99) < sender_idle_pct)
        begin
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
        end
    endtask

    task automatic write_all_regs(input logic [63:0] fa, input logic [63:0] fb,
                                  input logic [5:0] k, input logic [31:0] sa,
                                  input logic [31:0] sb, input logic [39:0] ta,
                                  input logic [39:0] tb);
        write_reg(kdda_pkg::REG_FREQS_FIRST, fa);
        write_reg(kdda_pkg::REG_FREQS_SECOND, fb);
        write_reg(kdda_pkg::REG_KMER_LEN, 64'(k));
        write_reg(kdda_pkg::REG_SEQS_FIRST, 64'(sa));
        write_reg(kdda_pkg::REG_SEQS_SECOND, 64'(sb));
        write_reg(kdda_pkg::REG_TOTAL_FIRST, 64'(ta));
        write_reg(kdda_pkg::REG_TOTAL_SECOND, 64'(tb));
    endtask

    function automatic logic [63:0] draw_freqs();
        if ($urandom_range(3) != 0)
            return {16'($urandom_range(16'h3000, 16'h5000)), 16'($urandom_range(16'h3000, 16'h5000)),
                    16'($urandom_range(16'h3000, 16'h5000)), 16'($urandom_range(16'h3000, 16'h5000))};
        return {$urandom, $urandom};
    endfunction

    function automatic logic [31:0] draw_count();
        case ($urandom_range(9))
            0, 1: return 0;
            2: return $urandom;
            default: return $urandom_range(1, 5000);
        endcase
    endfunction

    task automatic randomize_regs();
        logic [5:0]  k;
        logic [31:0] sa, sb;
        logic [39:0] ta, tb;
        k = ($urandom_range(9) == 0) ? 6'($urandom_range(63)) : 6'($urandom_range(1, 32));
        sa = ($urandom_range(4) == 0) ? $urandom : $urandom_range(1, 1000);
        sb = ($urandom_range(4) == 0) ? $urandom : $urandom_range(1, 1000);
        ta = ($urandom_range(3) == 0) ? {8'($urandom), $urandom} : 40'($urandom_range(0, 1 << 24));
        tb = ($urandom_range(3) == 0) ? {8'($urandom), $urandom} : 40'($urandom_range(0, 1 << 24));
        write_all_regs(draw_freqs(), draw_freqs(), k, sa, sb, ta, tb);
    endtask

    initial
    begin
        int frame_len;
        int sent;
        rst_n = 1'b0;
        cycle_count = 0;
        cfg_wr_en = 1'b0;
        cfg_addr = kdda_pkg::REG_FREQS_FIRST;
        cfg_wdata = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tlast = 1'b0;
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Defaults: zero total length, so the effective length is negative.
        send_record(64'h0, 32'd1, 32'd1, 1'b0);
        send_record(64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        send_record({$urandom, $urandom}, 32'd0, 32'd5, 1'b1);
        send_record({$urandom, $urandom}, 32'd0, 32'd0, 1'b1);
        s_axis_tvalid = 1'b0;
        drain_distances();

        // Zero length taken as one, huge sequence count
        write_all_regs(64'h1234_4000_ABCD_0001, 64'h4000_4000_4000_4000, 6'd0,
                       32'hFFFF_FFFF, 32'd1, 40'd0, 40'd1000);
        send_record({$urandom, $urandom}, 32'd7, 32'd9, 1'b0);
        send_record({$urandom, $urandom}, 32'hFFFF_FFFF, 32'd1, 1'b0);
        send_record(64'h0, 32'd1, 32'd100000, 1'b1);
        s_axis_tvalid = 1'b0;
        drain_distances();

        // Length above the maximum, all-ones frequencies, widest totals
        write_all_regs(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 6'd63,
                       32'd0, 32'd0, 40'hFF_FFFF_FFFF, 40'hFF_FFFF_FFFF);
        send_record(64'hFFFF_FFFF_FFFF_FFFF, 32'd1, 32'd1, 1'b0);
        send_record(64'h0, 32'hFFFF_FFFF, 32'd3, 1'b0);
        send_record({$urandom, $urandom}, 32'd2, 32'hFFFF_FFFF, 1'b1);
        s_axis_tvalid = 1'b0;
        drain_distances();

        // Zero frequencies: expected count vanishes
        write_all_regs(64'h0, 64'h0, 6'd32, 32'd3, 32'd5, 40'd12345, 40'd1);
        send_record({$urandom, $urandom}, 32'd4, 32'd8, 1'b0);
        send_record({$urandom, $urandom}, 32'd1, 32'd0, 1'b1);
        s_axis_tvalid = 1'b0;
        drain_distances();

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1: begin sender_idle_pct = 56; receiver_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  receiver_stall_pct = 56; end
                default: begin sender_idle_pct = 10; receiver_stall_pct = 10; end
            endcase
            sent = 0;
            while (sent < 250)
            begin
                if (sent % 80 == 0)
                begin
                    s_axis_tvalid = 1'b0;
                    drain_distances();
                    randomize_regs();
                end
                frame_len = $urandom_range(1, 6);
                for (int r = 0; r < frame_len; r++)
                    send_record({$urandom, $urandom}, draw_count(), draw_count(),
                                r == frame_len - 1);
                sent += frame_len;
                if (phase == 1 && sent > 120 && sent < 128)
                begin
                    s_axis_tvalid = 1'b0;
                    while (distances_pending != 0)
                        @(negedge clk);
                end
            end
        end
        s_axis_tvalid = 1'b0;
        drain_distances();

        if (mismatch_count == 0 && distances_pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
